[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge of clk_i outside reset.
`define ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check that post holds in the cycle after pre, outside reset.
`define ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

[hdl/dlte_pkg.sv]
// ----------------------------------------------------------------------------
// Line-table delta encoder package
// Request codes, result kinds and signed LEB128 helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dlte_pkg;

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_LOC   = 2'd1,
    REQ_END   = 2'd2
  } req_e;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_REGION = 1'b1;

  localparam int unsigned SegNum   = 5;
  localparam int unsigned SlebW    = 35;
  localparam int unsigned SegIdxW  = 3;
  localparam int unsigned ByteIdxW = 3;

  typedef logic [SlebW-1:0]    sleb_t;
  typedef logic [SegIdxW-1:0]  seg_idx_t;
  typedef logic [ByteIdxW-1:0] byte_idx_t;

  function automatic sleb_t sext32(logic [31:0] x);
    return {{(SlebW-32){x[31]}}, x};
  endfunction

  function automatic sleb_t zext32(logic [31:0] x);
    return {{(SlebW-32){1'b0}}, x};
  endfunction

  // Index of the final byte of the shortest encoding.
  function automatic byte_idx_t sleb_last_byte(sleb_t v);
    byte_idx_t r;
    if ((&v[34:6]) || !(|v[34:6])) begin
      r = 3'd0;
    end else if ((&v[34:13]) || !(|v[34:13])) begin
      r = 3'd1;
    end else if ((&v[34:20]) || !(|v[34:20])) begin
      r = 3'd2;
    end else if ((&v[34:27]) || !(|v[34:27])) begin
      r = 3'd3;
    end else begin
      r = 3'd4;
    end
    return r;
  endfunction

  function automatic logic [6:0] sleb_digit(sleb_t v, byte_idx_t idx);
    logic [6:0] d;
    case (idx)
      3'd0:    d = v[6:0];
      3'd1:    d = v[13:7];
      3'd2:    d = v[20:14];
      3'd3:    d = v[27:21];
      3'd4:    d = v[34:28];
      default: d = '0;
    endcase
    return d;
  endfunction

endpackage

[hdl/dlte_in_if.sv]
// ----------------------------------------------------------------------------
// Line-table request channel
// Valid/ready channel carrying one location-table request per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dlte_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] function_index;
  logic [31:0] address;
  logic [31:0] line;
  logic [31:0] column;
  logic [31:0] statement;
  logic [31:0] env_index;
  logic [31:0] file_id;
  logic [31:0] source_map_id;

  modport source (
    output valid, req_type, function_index, address, line, column,
    output statement, env_index, file_id, source_map_id,
    input  ready
  );

  modport sink (
    input  valid, req_type, function_index, address, line, column,
    input  statement, env_index, file_id, source_map_id,
    output ready
  );
endinterface

[hdl/dlte_out_if.sv]
// ----------------------------------------------------------------------------
// Line-table stream channel
// Valid/ready channel carrying one stream byte or region record per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dlte_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  data_byte;
  logic [31:0] byte_offset;
  logic [31:0] region_file;
  logic [31:0] region_map;
  logic        last;

  modport source (
    output valid, kind, data_byte, byte_offset, region_file, region_map, last,
    input  ready
  );

  modport sink (
    input  valid, kind, data_byte, byte_offset, region_file, region_map, last,
    output ready
  );
endinterface

[hdl/debug_line_table_delta_encoder_unit.sv]
// ----------------------------------------------------------------------------
// Line-table delta encoder
// Turns start, location and end requests into a signed LEB128 byte stream
// with file region records.
//
// Usage:
// - in_i takes one request per transfer: start, location or end. An unknown
//   request type is taken and dropped without results.
// - out_o gives one result per transfer: a data byte with its stream offset,
//   or a region record; last marks the final result of a request.
// - Each request gives 1 to 26 results, one per cycle while the receiver
//   takes them; the byte serializer sets that figure. The first result
//   passes through the serializer job register into the output register.
// - The next request is taken in the cycle the last result of the current
//   one moves into the output register, so requests run back to back.
// - A stalled receiver holds the output register; the serializer waits
//   behind it, and the request channel waits once a job is held.
// - Reset clears all previous values, the stream length and the region
//   history; the block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module debug_line_table_delta_encoder_unit import dlte_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  dlte_in_if.sink    in_i,
  dlte_out_if.source out_o
);

  // Encoder state
  logic [31:0] prev_address_q, prev_line_q, prev_column_q, prev_statement_q;
  logic [31:0] prev_env_q, prev_file_q, function_map_q, region_last_q;
  logic        region_seen_q;

  // Serializer job
  logic        job_vld_q;
  logic        reg_pend_q;
  logic [31:0] reg_file_q, reg_map_q;
  sleb_t       seg_val_q [SegNum];
  byte_idx_t   seg_lb_q  [SegNum];
  seg_idx_t    seg_last_q, seg_ptr_q;
  byte_idx_t   byte_ptr_q;
  logic [31:0] len_q;

  // Output register
  logic        out_vld_q, kind_q, last_q;
  logic [7:0]  byte_q;
  logic [31:0] off_q, rfile_q, rmap_q;

  // Request decode
  req_e        req;
  logic        in_acc, load;
  logic        reg_need;
  logic [31:0] reg_map_d;
  logic [31:0] ad, ld, cd, sd, ed;
  logic        sd_nz, ed_nz, line_nz;
  sleb_t       seg_d    [SegNum];
  byte_idx_t   seg_lb_d [SegNum];
  seg_idx_t    seg_last_d;

  // Emission
  logic        out_free, emit, emit_last, cont;
  sleb_t       cur_val;
  byte_idx_t   cur_lb;
  logic [6:0]  digit;

  assign req     = req_e'(in_i.req_type);
  assign in_acc  = in_i.valid && in_i.ready;
  assign ad      = in_i.address - prev_address_q;
  assign ld      = in_i.line - prev_line_q;
  assign cd      = in_i.column - prev_column_q;
  assign sd      = in_i.statement - prev_statement_q;
  assign ed      = in_i.env_index - prev_env_q;
  assign sd_nz   = (sd != '0);
  assign ed_nz   = (ed != '0);
  assign line_nz = (in_i.line != '0);

  always_comb begin
    load       = 1'b0;
    reg_need   = 1'b0;
    reg_map_d  = function_map_q;
    seg_last_d = '0;
    for (int i = 0; i < SegNum; i++) begin
      seg_d[i] = '0;
    end
    case (req)
      REQ_START: begin
        load       = in_acc;
        reg_need   = !region_seen_q || (region_last_q != in_i.file_id);
        reg_map_d  = in_i.source_map_id;
        seg_d[0]   = zext32(in_i.function_index);
        seg_d[1]   = zext32(in_i.line);
        seg_d[2]   = zext32(in_i.column);
        seg_d[3]   = zext32(in_i.env_index);
        seg_last_d = 3'd3;
      end
      REQ_LOC: begin
        load     = in_acc;
        reg_need = (in_i.file_id != prev_file_q);
        seg_d[0] = sext32(ad);
        if (line_nz) begin
          seg_d[1]   = {ld, ed_nz, sd_nz, 1'b1};
          seg_d[2]   = sext32(cd);
          seg_d[3]   = sd_nz ? sext32(sd) : sext32(ed);
          seg_d[4]   = sext32(ed);
          seg_last_d = 3'd2 + {2'b00, sd_nz} + {2'b00, ed_nz};
        end else begin
          seg_last_d = 3'd1;
        end
      end
      REQ_END: begin
        load       = in_acc;
        seg_d[0]   = '1;
        seg_last_d = 3'd0;
      end
      default: ;
    endcase
    for (int i = 0; i < SegNum; i++) begin
      seg_lb_d[i] = sleb_last_byte(seg_d[i]);
    end
  end

  assign out_free  = !out_vld_q || out_o.ready;
  assign emit      = job_vld_q && out_free;
  assign cur_val   = seg_val_q[seg_ptr_q];
  assign cur_lb    = seg_lb_q[seg_ptr_q];
  assign cont      = (byte_ptr_q != cur_lb);
  assign digit     = sleb_digit(cur_val, byte_ptr_q);
  assign emit_last = !reg_pend_q && !cont && (seg_ptr_q == seg_last_q);

  assign in_i.ready = !job_vld_q || (emit && emit_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_address_q   <= '0;
      prev_line_q      <= '0;
      prev_column_q    <= '0;
      prev_statement_q <= '0;
      prev_env_q       <= '0;
      prev_file_q      <= '0;
      function_map_q   <= '0;
      region_seen_q    <= 1'b0;
      region_last_q    <= '0;
    end else if (in_acc) begin
      if (load && reg_need) begin
        region_seen_q <= 1'b1;
        region_last_q <= in_i.file_id;
      end
      case (req)
        REQ_START: begin
          function_map_q   <= in_i.source_map_id;
          prev_address_q   <= in_i.address;
          prev_line_q      <= in_i.line;
          prev_column_q    <= in_i.column;
          prev_statement_q <= in_i.statement;
          prev_env_q       <= in_i.env_index;
          prev_file_q      <= in_i.file_id;
        end
        REQ_LOC: begin
          prev_address_q <= in_i.address;
          if (line_nz) begin
            prev_line_q      <= in_i.line;
            prev_column_q    <= in_i.column;
            prev_statement_q <= in_i.statement;
            prev_env_q       <= in_i.env_index;
            prev_file_q      <= in_i.file_id;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_vld_q  <= 1'b0;
      reg_pend_q <= 1'b0;
      seg_last_q <= '0;
      seg_ptr_q  <= '0;
      byte_ptr_q <= '0;
      len_q      <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      if (out_free) begin
        out_vld_q <= emit;
      end
      if (emit && !reg_pend_q) begin
        len_q <= len_q + 32'd1;
      end
      if (load) begin
        job_vld_q  <= 1'b1;
        reg_pend_q <= reg_need;
        seg_last_q <= seg_last_d;
        seg_ptr_q  <= '0;
        byte_ptr_q <= '0;
      end else if (emit) begin
        if (emit_last) begin
          job_vld_q <= 1'b0;
        end
        if (reg_pend_q) begin
          reg_pend_q <= 1'b0;
        end else if (cont) begin
          byte_ptr_q <= byte_ptr_q + 3'd1;
        end else begin
          byte_ptr_q <= '0;
          seg_ptr_q  <= seg_ptr_q + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      reg_file_q <= in_i.file_id;
      reg_map_q  <= reg_map_d;
      for (int i = 0; i < SegNum; i++) begin
        seg_val_q[i] <= seg_d[i];
        seg_lb_q[i]  <= seg_lb_d[i];
      end
    end
    if (emit) begin
      off_q <= len_q;
      if (reg_pend_q) begin
        kind_q  <= KIND_REGION;
        byte_q  <= '0;
        rfile_q <= reg_file_q;
        rmap_q  <= reg_map_q;
        last_q  <= 1'b0;
      end else begin
        kind_q  <= KIND_DATA;
        byte_q  <= {cont, digit};
        rfile_q <= '0;
        rmap_q  <= '0;
        last_q  <= emit_last;
      end
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.kind        = kind_q;
  assign out_o.data_byte   = byte_q;
  assign out_o.byte_offset = off_q;
  assign out_o.region_file = rfile_q;
  assign out_o.region_map  = rmap_q;
  assign out_o.last        = last_q;

  `ASSERT_RST(a_region_not_last,
    out_o.valid && (out_o.kind == KIND_REGION) |-> !out_o.last,
    "region record marked as final result")
  `ASSERT_RST(a_cont_not_last,
    out_o.valid && (out_o.kind == KIND_DATA) && out_o.data_byte[7] |-> !out_o.last,
    "continued byte marked as final result")
  `ASSERT_RST(a_job_ends_on_last,
    $fell(job_vld_q) |-> $past(emit && emit_last),
    "job dropped before its final result")
  `ASSERT_NEXT(a_len_advance,
    emit && !reg_pend_q,
    len_q == $past(len_q) + 32'd1,
    "stream length out of step with data bytes")

endmodule
